### rtl/aes128_block_encrypt_macros.svh
// Assertion macros used by the cipher top level.
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/aes_pkg.sv
// Package with the cipher's types, constants and GF(2^8) functions.
`timescale 1ns / 1ps
package aes_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned CfgIdxW   = 1;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;
  localparam logic [7:0] Poly   = 8'h1b;
  localparam logic [7:0] TopBit = 8'h80;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic   vld;
    block_t state;
    block_t rkey;
    byte_t  rcon;
  } cell_bus_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (((a & TopBit) != 8'h00) ? Poly : 8'h00);
  endfunction

  // byte k of the block sits at bits 127-8k downto 120-8k
  function automatic byte_t get_byte(input block_t b, input int k);
    get_byte = b[BlockW-1-8*k -: 8];
  endfunction
endpackage

### rtl/aes_stream_if.sv
// Valid/ready channel carrying one 128-bit block as two halves.
`timescale 1ns / 1ps
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] hi;
  logic [63:0] lo;
  modport source (output valid, output hi, output lo, input ready);
  modport sink (input valid, input hi, input lo, output ready);
endinterface

### rtl/aes_cfg_if.sv
// Configuration write channel: register index and data.
`timescale 1ns / 1ps
interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/aes_round_cell.sv
// One round cell: cipher round plus key-schedule step, registered.
`timescale 1ns / 1ps
module aes_round_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               last,
  input  aes_pkg::cell_bus_t in_bus,
  output aes_pkg::cell_bus_t out_bus
);
  import aes_pkg::*;

  block_t sr, mc, nkey, nstate;
  byte_t  t0, t1, t2, t3, a0, a1, a2, a3;
  logic   vld_r;
  block_t state_r, rkey_r;
  byte_t  rcon_r;

  always_comb begin
    // sub bytes and shift rows together
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[BlockW-1-8*(c*4+r) -: 8] = SBOX[get_byte(in_bus.state, ((c + r) & 3) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(sr, c*4);
      a1 = get_byte(sr, c*4+1);
      a2 = get_byte(sr, c*4+2);
      a3 = get_byte(sr, c*4+3);
      mc[BlockW-1-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mc[BlockW-1-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mc[BlockW-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mc[BlockW-1-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    // next round key from the key handed in
    t0 = SBOX[get_byte(in_bus.rkey, 13)] ^ in_bus.rcon;
    t1 = SBOX[get_byte(in_bus.rkey, 14)];
    t2 = SBOX[get_byte(in_bus.rkey, 15)];
    t3 = SBOX[get_byte(in_bus.rkey, 12)];
    nkey[127:96] = in_bus.rkey[127:96] ^ {t0, t1, t2, t3};
    nkey[95:64]  = in_bus.rkey[95:64] ^ nkey[127:96];
    nkey[63:32]  = in_bus.rkey[63:32] ^ nkey[95:64];
    nkey[31:0]   = in_bus.rkey[31:0] ^ nkey[63:32];
    nstate = (last ? sr : mc) ^ nkey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_bus.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= nstate;
      rkey_r  <= nkey;
      rcon_r  <= xtime(in_bus.rcon);
    end
  end

  assign out_bus = '{vld: vld_r, state: state_r, rkey: rkey_r, rcon: rcon_r};
endmodule

### rtl/aes128_block_encrypt.sv
// AES-128 encryption engine: a row of ten round cells behind a whitening stage.
// Path: each input word is registered in the whitening stage, then in each of the ten round cells in turn.
// Throughput: one block per cycle; each cell holds one block, and the row advances
// whenever the last cell is empty or its result word is taken.
// Reset (rst_n low, synchronous): all cells empty, both key registers zero.
`timescale 1ns / 1ps
module aes128_block_encrypt (
  input logic      clk,
  input logic      rst_n,
  aes_stream_if.sink   in_if,
  aes_stream_if.source out_if,
  aes_cfg_if.sink      cfg_if
);
  import aes_pkg::*;
  `include "aes128_block_encrypt_macros.svh"

  logic [HalfW-1:0] key_high_r, key_low_r;
  cell_bus_t        bus [NumRounds+1];
  logic             vld0_r;
  block_t           st0_r, key0_r;
  logic             adv;

  // the row moves together; stalls only when a result waits
  assign adv = !bus[NumRounds].vld || out_if.ready;
  assign in_if.ready  = adv;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        RegKeyHigh: key_high_r <= cfg_if.data;
        RegKeyLow:  key_low_r  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_if.valid;
    end
  end

  // add round key 0; carry the key down the row with the block
  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r  <= {in_if.hi, in_if.lo} ^ {key_high_r, key_low_r};
      key0_r <= {key_high_r, key_low_r};
    end
  end

  assign bus[0] = '{vld: vld0_r, state: st0_r, rkey: key0_r, rcon: 8'h01};

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .last    (g == NumRounds - 1),
      .in_bus  (bus[g]),
      .out_bus (bus[g+1])
    );
  end

  assign out_if.valid = bus[NumRounds].vld;
  assign out_if.hi    = bus[NumRounds].state[BlockW-1:HalfW];
  assign out_if.lo    = bus[NumRounds].state[HalfW-1:0];

  `AES_ASSERT_IMP(a_no_stall_when_free, clk, rst_n, !out_if.valid, in_if.ready)
  `AES_ASSERT_NXT(a_hold_on_stall, clk, rst_n, out_if.valid && !out_if.ready,
                  out_if.valid && $stable(out_if.hi) && $stable(out_if.lo))
  `AES_ASSERT_NXT(a_take_lands, clk, rst_n, in_if.valid && in_if.ready, vld0_r)
endmodule
